### sv/urng_pkg.sv
// ----------------------------------------------------------------------------
// urng_pkg - shared types and constants of the dual ultrasonic ranger
// Phase codes, register indexes, reset values and the structs that pass
// between the configuration bank, the sequencer and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package urng_pkg;

  localparam int unsigned CntW   = 24;
  localparam int unsigned ShortW = 8;
  localparam int unsigned DistW  = 16;
  localparam int unsigned StatW  = 2;
  localparam int unsigned IdxW   = 3;

  // Register indexes on the write port
  localparam logic [IdxW-1:0] RegTriggerTicks = 3'd0;
  localparam logic [IdxW-1:0] RegRiseTimeout  = 3'd1;
  localparam logic [IdxW-1:0] RegEchoTimeout  = 3'd2;
  localparam logic [IdxW-1:0] RegSettleTicks  = 3'd3;
  localparam logic [IdxW-1:0] RegPauseTicks   = 3'd4;
  localparam logic [IdxW-1:0] RegTicksPerCm   = 3'd5;

  // Reset values
  localparam logic [ShortW-1:0] RstTriggerTicks = 8'd10;
  localparam logic [CntW-1:0]   RstRiseTimeout  = 24'd20000;
  localparam logic [CntW-1:0]   RstEchoTimeout  = 24'd20000;
  localparam logic [CntW-1:0]   RstSettleTicks  = 24'd60000;
  localparam logic [CntW-1:0]   RstPauseTicks   = 24'd1000000;
  localparam logic [ShortW-1:0] RstTicksPerCm   = 8'd30;

  localparam logic [DistW-1:0] DistMax = 16'hFFFF;

  // Report status
  localparam logic [StatW-1:0] StatOk       = 2'd0;
  localparam logic [StatW-1:0] StatNoRise   = 2'd1;
  localparam logic [StatW-1:0] StatEchoLong = 2'd2;

  typedef enum logic [2:0] {
    PH_STARTUP   = 3'd0,
    PH_TRIGGER   = 3'd1,
    PH_WAIT_RISE = 3'd2,
    PH_MEASURE   = 3'd3,
    PH_SETTLE    = 3'd4,
    PH_PAUSE     = 3'd5
  } phase_t;

  typedef struct packed {
    logic [ShortW-1:0] trigger_ticks;
    logic [CntW-1:0]   rise_timeout;
    logic [CntW-1:0]   echo_timeout;
    logic [CntW-1:0]   settle_ticks;
    logic [CntW-1:0]   pause_ticks;
    logic [ShortW-1:0] ticks_per_cm;
  } cfg_t;

  // One result word, fields in tdata order from the highest bit
  typedef struct packed {
    logic [StatW-1:0] status_code;
    logic [DistW-1:0] distance_cm;
    logic             sensor_index;
    logic             report_valid;
    logic             trigger_second;
    logic             trigger_first;
  } res_t;

endpackage

`default_nettype wire

### sv/urng_cfg.sv
// ----------------------------------------------------------------------------
// urng_cfg - configuration register bank
// Six write-only registers loaded from the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module urng_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr_en,
  input  wire logic [urng_pkg::IdxW-1:0]  wr_index,
  input  wire logic [urng_pkg::CntW-1:0]  wr_data,
  output urng_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_ticks <= urng_pkg::RstTriggerTicks;
      cfg.rise_timeout  <= urng_pkg::RstRiseTimeout;
      cfg.echo_timeout  <= urng_pkg::RstEchoTimeout;
      cfg.settle_ticks  <= urng_pkg::RstSettleTicks;
      cfg.pause_ticks   <= urng_pkg::RstPauseTicks;
      cfg.ticks_per_cm  <= urng_pkg::RstTicksPerCm;
    end else if (wr_en) begin
      case (wr_index)
        urng_pkg::RegTriggerTicks: cfg.trigger_ticks <= wr_data[urng_pkg::ShortW-1:0];
        urng_pkg::RegRiseTimeout:  cfg.rise_timeout  <= wr_data;
        urng_pkg::RegEchoTimeout:  cfg.echo_timeout  <= wr_data;
        urng_pkg::RegSettleTicks:  cfg.settle_ticks  <= wr_data;
        urng_pkg::RegPauseTicks:   cfg.pause_ticks   <= wr_data;
        urng_pkg::RegTicksPerCm:   cfg.ticks_per_cm  <= wr_data[urng_pkg::ShortW-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/urng_seq.sv
// ----------------------------------------------------------------------------
// urng_seq - ranging sequencer
// Phase machine, gap/timeout counter, cm prescaler and distance counter.
// Result for the current tick is combinational; state moves on tick_en.
// ----------------------------------------------------------------------------
`default_nettype none

module urng_seq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           tick_en,
  input  wire logic           echo_first,
  input  wire logic           echo_second,
  input  wire urng_pkg::cfg_t cfg,
  output urng_pkg::res_t      res
);

  urng_pkg::phase_t              phase, phase_next;
  logic                          active_sensor, active_sensor_next;
  logic [urng_pkg::CntW-1:0]     phase_count, phase_count_next;
  logic [urng_pkg::ShortW-1:0]   cm_prescale, cm_prescale_next;
  logic [urng_pkg::DistW-1:0]    distance_count, distance_count_next;

  logic                          echo;
  logic [urng_pkg::CntW-1:0]     cnt_inc;
  logic                          measure;
  logic [urng_pkg::CntW-1:0]     m_cnt;
  logic [urng_pkg::ShortW-1:0]   m_presc;
  logic [urng_pkg::DistW-1:0]    m_dist;
  logic                          rise_fail;
  logic                          echo_long;
  logic                          presc_wrap;

  assign echo    = active_sensor ? echo_second : echo_first;
  assign cnt_inc = phase_count + 24'd1;

  // A rise on this tick starts measuring with cleared counters
  assign measure = (phase == urng_pkg::PH_MEASURE) ||
                   ((phase == urng_pkg::PH_WAIT_RISE) && echo);
  assign m_cnt   = (phase == urng_pkg::PH_MEASURE) ? phase_count    : '0;
  assign m_presc = (phase == urng_pkg::PH_MEASURE) ? cm_prescale    : '0;
  assign m_dist  = (phase == urng_pkg::PH_MEASURE) ? distance_count : '0;

  assign rise_fail  = (phase == urng_pkg::PH_WAIT_RISE) && !echo &&
                      (phase_count >= cfg.rise_timeout);
  assign echo_long  = measure && echo && (m_cnt >= cfg.echo_timeout);
  assign presc_wrap = ({1'b0, m_presc} + 9'd1) >= {1'b0, cfg.ticks_per_cm};

  // Next state
  always_comb begin
    phase_next          = phase;
    active_sensor_next  = active_sensor;
    phase_count_next    = phase_count;
    cm_prescale_next    = cm_prescale;
    distance_count_next = distance_count;
    case (phase)
      urng_pkg::PH_STARTUP: begin
        if (cnt_inc >= cfg.settle_ticks) begin
          active_sensor_next = 1'b0;
          phase_next         = urng_pkg::PH_TRIGGER;
          phase_count_next   = '0;
        end else begin
          phase_count_next = cnt_inc;
        end
      end
      urng_pkg::PH_TRIGGER: begin
        if (cnt_inc >= {16'd0, cfg.trigger_ticks}) begin
          phase_next       = urng_pkg::PH_WAIT_RISE;
          phase_count_next = '0;
        end else begin
          phase_count_next = cnt_inc;
        end
      end
      urng_pkg::PH_WAIT_RISE, urng_pkg::PH_MEASURE: begin
        if (measure) begin
          phase_next = urng_pkg::PH_MEASURE;
          if (!echo || echo_long) begin
            phase_next          = urng_pkg::PH_SETTLE;
            phase_count_next    = '0;
            cm_prescale_next    = m_presc;
            distance_count_next = m_dist;
          end else begin
            phase_count_next = m_cnt + 24'd1;
            if (presc_wrap) begin
              cm_prescale_next    = '0;
              distance_count_next = (m_dist != urng_pkg::DistMax) ? m_dist + 16'd1 : m_dist;
            end else begin
              cm_prescale_next    = m_presc + 8'd1;
              distance_count_next = m_dist;
            end
          end
        end else if (rise_fail) begin
          phase_next       = urng_pkg::PH_SETTLE;
          phase_count_next = '0;
        end else begin
          phase_count_next = cnt_inc;
        end
      end
      urng_pkg::PH_SETTLE: begin
        if (cnt_inc >= cfg.settle_ticks) begin
          phase_count_next = '0;
          if (!active_sensor) begin
            active_sensor_next = 1'b1;
            phase_next         = urng_pkg::PH_TRIGGER;
          end else begin
            phase_next = urng_pkg::PH_PAUSE;
          end
        end else begin
          phase_count_next = cnt_inc;
        end
      end
      urng_pkg::PH_PAUSE: begin
        if (cnt_inc >= cfg.pause_ticks) begin
          active_sensor_next = 1'b0;
          phase_next         = urng_pkg::PH_TRIGGER;
          phase_count_next   = '0;
        end else begin
          phase_count_next = cnt_inc;
        end
      end
      default: begin
        phase_next          = urng_pkg::PH_STARTUP;
        active_sensor_next  = 1'b0;
        phase_count_next    = '0;
        cm_prescale_next    = '0;
        distance_count_next = '0;
      end
    endcase
  end

  // Outputs for this tick
  always_comb begin
    res = '0;
    res.trigger_first  = (phase == urng_pkg::PH_TRIGGER) && !active_sensor;
    res.trigger_second = (phase == urng_pkg::PH_TRIGGER) && active_sensor;
    if (measure && !echo) begin
      res.report_valid = 1'b1;
      res.status_code  = urng_pkg::StatOk;
      res.distance_cm  = m_dist;
    end else if (echo_long) begin
      res.report_valid = 1'b1;
      res.status_code  = urng_pkg::StatEchoLong;
    end else if (rise_fail) begin
      res.report_valid = 1'b1;
      res.status_code  = urng_pkg::StatNoRise;
    end
    res.sensor_index = res.report_valid & active_sensor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= urng_pkg::PH_STARTUP;
      active_sensor  <= 1'b0;
      phase_count    <= '0;
      cm_prescale    <= '0;
      distance_count <= '0;
    end else if (tick_en) begin
      phase          <= phase_next;
      active_sensor  <= active_sensor_next;
      phase_count    <= phase_count_next;
      cm_prescale    <= cm_prescale_next;
      distance_count <= distance_count_next;
    end
  end

endmodule

`default_nettype wire

### sv/dual_ultrasonic_ranger_unit.sv
// ----------------------------------------------------------------------------
// dual_ultrasonic_ranger_unit - two-sensor ultrasonic echo ranging controller
// One input word per microsecond tick with both echo levels; one result word
// per tick with trigger levels and, at the end of a measurement, a report.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  s_axis    in         s_axis_tvalid/tready      tick: echo levels
//  m_axis    out        m_axis_tvalid/tready      tick result: triggers, report
//  config    in         wr_en (no wait)           wr_index, wr_data
//
// Flow: one word a cycle sustained while results are taken; a tick is held in the input
//   register, passes the sequencer logic and lands in the result register,
//   from which its result is offered.
// Reset: rst clears the phase machine to the start-up settle gap, all
//   counters to zero and the registers to their defaults.
// Stalls: a full input register advances only with the result register; a
//   held result holds the input register, and s_axis_tready drops only
//   while both are full and the result is not being taken.
//
`default_nettype none

module dual_ultrasonic_ranger_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // input words
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [0] echo_first, [1] echo_second, [7:2] zero
  // result words
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [0] trigger_first, [1] trigger_second,
                                           // [2] report_valid, [3] sensor_index,
                                           // [19:4] distance_cm, [21:20] status_code,
                                           // [23:22] zero
  // register writes
  input  wire logic        wr_en,
  input  wire logic [2:0]  wr_index,
  input  wire logic [23:0] wr_data
);

  urng_pkg::cfg_t cfg;
  urng_pkg::res_t res;

  logic       in_valid;
  logic [1:0] in_echo;
  logic       out_valid;
  logic [$bits(urng_pkg::res_t)-1:0] out_data;
  logic       advance;

  // Result register free, or emptied this cycle
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;

  urng_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  // Sequencer state steps exactly once per tick moved to the result register
  urng_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .tick_en     (in_valid && advance),
    .echo_first  (in_echo[0]),
    .echo_second (in_echo[1]),
    .cfg         (cfg),
    .res         (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_echo <= s_axis_tdata[1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_data <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_data};

endmodule

`default_nettype wire

### sv/urng_checker.sv
// ----------------------------------------------------------------------------
// urng_checker - port-level checks of the ranger
// Output handshake and result word consistency, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module urng_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata
);

  // held result keeps its word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // only one trigger driven, and never in a report word
  a_trig_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]) &&
                      !((m_axis_tdata[0] || m_axis_tdata[1]) && m_axis_tdata[2]))
    else $error("trigger overlap");

  // no report: sensor, distance and status are zero
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[23:3] == 21'd0)
    else $error("fields set without report");

  // an error reports zero distance and a known code
  a_err_dist: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[21:20] != 2'd0 |->
      m_axis_tdata[21:20] != 2'd3 && m_axis_tdata[19:4] == 16'd0)
    else $error("bad error report");

endmodule

bind dual_ultrasonic_ranger_unit urng_checker u_urng_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
